/* rtl/segfl_pkg.sv */
package segfl_pkg;

  localparam int unsigned DefSlots   = 64;
  localparam int unsigned ClassCount = 10;
  localparam int unsigned AddrW      = 48;
  localparam int unsigned SizeW      = 32;
  localparam int unsigned ClassW     = 4;
  localparam int unsigned AgeW       = 32;
  localparam int unsigned TotalW     = 39;
  localparam int unsigned OutCntW    = 7;
  localparam int unsigned CmdW       = 2;
  localparam int unsigned StatW      = 2;
  localparam int unsigned MinRem     = 16;
  localparam int unsigned MinClass   = 16;

  typedef enum logic [CmdW-1:0] {
    CmdAdd, CmdAlloc, CmdCoalesce, CmdNop
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    StatOk, StatNoFit, StatFull
  } stat_e;

  typedef enum logic [3:0] {
    StIdle, StAdd, StScan, StTake, StSort1, StMerge, StFix, StSort2, StAssign, StFin
  } state_e;

  typedef struct packed {
    logic              valid;
    logic [AddrW-1:0]  addr;
    logic [SizeW-1:0]  size;
    logic [ClassW-1:0] cls;
    logic [AgeW-1:0]   age;
  } rec_t;

  typedef struct packed {
    logic shift;      // whole row moves one place toward the head
    logic head_load;  // head cell loads alone
    logic use_alt;    // head cell takes the alternate record
  } ring_ctl_t;

  function automatic logic [ClassW-1:0] class_of(logic [SizeW-1:0] size);
    logic [ClassW-1:0] c;
    c = '0;
    for (int k = 0; k < ClassCount - 1; k++) begin
      if (size > (SizeW'(MinClass) << k)) c = ClassW'(k + 1);
    end
    return c;
  endfunction

  // empty records order after all valid ones
  function automatic logic rec_gt(rec_t a, rec_t b);
    if (!a.valid) return b.valid;
    if (!b.valid) return 1'b0;
    return {a.addr, a.size} > {b.addr, b.size};
  endfunction

endpackage

/* rtl/segregated_free_list_allocator.sv */
// work per command, n = TABLE_SLOTS slots, counted in trips of the slot row past its head:
//   add one trip, allocate a scan trip, then a take trip if a block fits; unknown command none;
//   coalesce two bubble sorts of n trips each, one merge trip, one fix step, one age trip
// one command at a time: start is taken again in the cycle the done strobe shows
// results stand on the ports for the single done cycle, the receiver cannot stall
// reset empties every slot and clears the age counter and the free byte total
module segregated_free_list_allocator #(
  parameter int unsigned TABLE_SLOTS = segfl_pkg::DefSlots
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [segfl_pkg::CmdW-1:0]      command_i,
  input  logic [segfl_pkg::AddrW-1:0]     block_address_i,
  input  logic [segfl_pkg::SizeW-1:0]     byte_size_i,
  output logic                            busy_o,
  output logic                            done_o,
  output logic [segfl_pkg::StatW-1:0]     status_o,
  output logic [segfl_pkg::AddrW-1:0]     granted_address_o,
  output logic [segfl_pkg::OutCntW-1:0]   merge_count_o,
  output logic [segfl_pkg::TotalW-1:0]    free_bytes_o,
  output logic [segfl_pkg::OutCntW-1:0]   block_total_o
);

  segfl_pkg::rec_t      row_q [TABLE_SLOTS];
  segfl_pkg::rec_t      tail, alt;
  segfl_pkg::ring_ctl_t ctl;

  segfl_ctrl #(.Slots(TABLE_SLOTS)) u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .command_i         (command_i),
    .block_address_i   (block_address_i),
    .byte_size_i       (byte_size_i),
    .h0_i              (row_q[0]),
    .h1_i              (row_q[1]),
    .tail_o            (tail),
    .alt_o             (alt),
    .ctl_o             (ctl),
    .busy_o            (busy_o),
    .done_o            (done_o),
    .status_o          (status_o),
    .granted_address_o (granted_address_o),
    .merge_count_o     (merge_count_o),
    .free_bytes_o      (free_bytes_o),
    .block_total_o     (block_total_o)
  );

  for (genvar i = 0; i < TABLE_SLOTS; i++) begin : g_cell
    segfl_pkg::rec_t d;
    logic            en;
    if (i == 0) begin : g_head
      assign d  = ctl.use_alt ? alt : row_q[1];
      assign en = ctl.shift || ctl.head_load;
    end else if (i == TABLE_SLOTS - 1) begin : g_tail
      assign d  = tail;
      assign en = ctl.shift;
    end else begin : g_mid
      assign d  = row_q[i+1];
      assign en = ctl.shift;
    end
    segfl_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .d_i    (d),
      .q_o    (row_q[i])
    );
  end

endmodule

/* rtl/segfl_cell.sv */
module segfl_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  segfl_pkg::rec_t d_i,
  output segfl_pkg::rec_t q_o
);

  logic            valid_q;
  segfl_pkg::rec_t data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= d_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= d_i;
    end
  end

  always_comb begin
    q_o       = data_q;
    q_o.valid = valid_q;
  end

endmodule

/* rtl/segfl_ctrl.sv */
module segfl_ctrl #(
  parameter int unsigned Slots = segfl_pkg::DefSlots
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [segfl_pkg::CmdW-1:0]          command_i,
  input  logic [segfl_pkg::AddrW-1:0]         block_address_i,
  input  logic [segfl_pkg::SizeW-1:0]         byte_size_i,
  input  segfl_pkg::rec_t                     h0_i,
  input  segfl_pkg::rec_t                     h1_i,
  output segfl_pkg::rec_t                     tail_o,
  output segfl_pkg::rec_t                     alt_o,
  output segfl_pkg::ring_ctl_t                ctl_o,
  output logic                                busy_o,
  output logic                                done_o,
  output logic [segfl_pkg::StatW-1:0]         status_o,
  output logic [segfl_pkg::AddrW-1:0]         granted_address_o,
  output logic [segfl_pkg::OutCntW-1:0]       merge_count_o,
  output logic [segfl_pkg::TotalW-1:0]        free_bytes_o,
  output logic [segfl_pkg::OutCntW-1:0]       block_total_o
);

  localparam int unsigned IW = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int unsigned CW = $clog2(Slots + 1);
  localparam int unsigned AW = segfl_pkg::AddrW;
  localparam int unsigned SW = segfl_pkg::SizeW;
  localparam int unsigned TW = segfl_pkg::TotalW;

  segfl_pkg::state_e state_q, state_d;

  logic [IW-1:0]   pos_q, pass_q, best_idx_q;
  logic [SW:0]     req_q;
  logic [AW-1:0]   addr_q, best_addr_q, gaddr_q;
  logic [SW-1:0]   size_q, best_size_q, best_dist_q;
  logic [segfl_pkg::ClassW-1:0] best_cls_q;
  logic            best_v_q, flag_q, done_q;
  logic [segfl_pkg::AgeW-1:0] ctr_q;
  logic [TW-1:0]   ft_q, ft_d;
  logic [CW-1:0]   cnt_q, cnt_d, mrg_q;
  logic [segfl_pkg::OutCntW-1:0] mout_q;
  segfl_pkg::stat_e stat_q;
  segfl_pkg::rec_t acc_q;

  logic            accept, last_pos, last_pass, take_hit, slot_free, need_ins;
  logic            fit, better, mergeable, gt, ins, rm;
  logic [SW:0]     round;
  logic [SW-1:0]   rem, age_gap, ins_size;
  logic [AW:0]     acc_end;
  logic [SW:0]     size_sum;

  function automatic segfl_pkg::rec_t mk_rec(logic [AW-1:0] a, logic [SW-1:0] s,
                                             logic [segfl_pkg::AgeW-1:0] age);
    segfl_pkg::rec_t r;
    r.valid = 1'b1;
    r.addr  = a;
    r.size  = s;
    r.cls   = segfl_pkg::class_of(s);
    r.age   = age;
    return r;
  endfunction

  assign busy_o    = (state_q != segfl_pkg::StIdle);
  assign accept    = start_i && !busy_o;
  assign last_pos  = (pos_q == IW'(Slots - 1));
  assign last_pass = (pass_q == IW'(Slots - 1));
  assign round     = ({1'b0, byte_size_i} + (SW+1)'(7)) & ~(SW+1)'(7);
  assign rem       = best_size_q - req_q[SW-1:0];
  assign need_ins  = (rem >= SW'(segfl_pkg::MinRem));
  assign take_hit  = (pos_q == best_idx_q);
  assign slot_free = !h0_i.valid || ((state_q == segfl_pkg::StTake) && take_hit);
  assign fit       = h0_i.valid && ({1'b0, h0_i.size} >= req_q);
  assign age_gap   = ctr_q - h0_i.age;
  assign better    = fit && (!best_v_q || (h0_i.cls < best_cls_q) ||
                     ((h0_i.cls == best_cls_q) && (age_gap < best_dist_q)));
  assign acc_end   = {1'b0, acc_q.addr} + (AW+1)'(acc_q.size);
  assign size_sum  = {1'b0, acc_q.size} + {1'b0, h0_i.size};
  assign mergeable = acc_q.valid && h0_i.valid && (acc_end == {1'b0, h0_i.addr}) &&
                     !size_sum[SW];
  assign gt        = segfl_pkg::rec_gt(h0_i, h1_i);
  assign rm        = (state_q == segfl_pkg::StTake) && take_hit;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      segfl_pkg::StIdle: begin
        if (accept) begin
          unique case (segfl_pkg::cmd_e'(command_i))
            segfl_pkg::CmdAdd:      state_d = segfl_pkg::StAdd;
            segfl_pkg::CmdAlloc:    state_d = round[SW] ? segfl_pkg::StFin : segfl_pkg::StScan;
            segfl_pkg::CmdCoalesce: state_d = segfl_pkg::StSort1;
            default:                state_d = segfl_pkg::StFin;
          endcase
        end
      end
      segfl_pkg::StAdd:    if (last_pos) state_d = segfl_pkg::StFin;
      segfl_pkg::StScan: begin
        if (last_pos) state_d = (best_v_q || better) ? segfl_pkg::StTake : segfl_pkg::StFin;
      end
      segfl_pkg::StTake:   if (last_pos) state_d = segfl_pkg::StFin;
      segfl_pkg::StSort1:  if (last_pos && last_pass) state_d = segfl_pkg::StMerge;
      segfl_pkg::StMerge:  if (last_pos) state_d = segfl_pkg::StFix;
      segfl_pkg::StFix:    state_d = segfl_pkg::StSort2;
      segfl_pkg::StSort2:  if (last_pos && last_pass) state_d = segfl_pkg::StAssign;
      segfl_pkg::StAssign: if (last_pos) state_d = segfl_pkg::StFin;
      segfl_pkg::StFin:    state_d = segfl_pkg::StIdle;
      default:             state_d = segfl_pkg::StIdle;
    endcase
  end

  // row control and head records
  always_comb begin
    ctl_o    = '0;
    tail_o   = h0_i;
    alt_o    = h1_i;
    ins      = 1'b0;
    ins_size = '0;
    unique case (state_q)
      segfl_pkg::StAdd: begin
        ctl_o.shift = 1'b1;
        if (!h0_i.valid && !flag_q) begin
          tail_o   = mk_rec(addr_q, size_q, ctr_q);
          ins      = 1'b1;
          ins_size = size_q;
        end
      end
      segfl_pkg::StScan: ctl_o.shift = 1'b1;
      segfl_pkg::StTake: begin
        ctl_o.shift = 1'b1;
        if (take_hit) tail_o.valid = 1'b0;
        if (slot_free && need_ins && !flag_q) begin
          tail_o   = mk_rec(best_addr_q + AW'(req_q), rem, ctr_q);
          ins      = 1'b1;
          ins_size = rem;
        end
      end
      segfl_pkg::StSort1, segfl_pkg::StSort2: begin
        ctl_o.shift = 1'b1;
        // bubble pass: larger record rides along the head, smaller goes to tail
        if (!last_pos) begin
          ctl_o.use_alt = 1'b1;
          tail_o = gt ? h1_i : h0_i;
          alt_o  = gt ? h0_i : h1_i;
        end
      end
      segfl_pkg::StMerge: begin
        ctl_o.shift = 1'b1;
        if (mergeable) tail_o.valid = 1'b0;
        else tail_o = acc_q;
      end
      segfl_pkg::StFix: begin
        // slot 0 is empty after the merge pass, park the last run there
        ctl_o.head_load = 1'b1;
        ctl_o.use_alt   = 1'b1;
        alt_o           = acc_q;
      end
      segfl_pkg::StAssign: begin
        ctl_o.shift = 1'b1;
        if (h0_i.valid) begin
          tail_o.age = ctr_q;
          tail_o.cls = segfl_pkg::class_of(h0_i.size);
          ins        = 1'b1;
          ins_size   = h0_i.size;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    ft_d  = ft_q + TW'(ins_size) - (rm ? TW'(best_size_q) : TW'(0));
    cnt_d = cnt_q + CW'(ins) - CW'(rm);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= segfl_pkg::StIdle;
      pos_q    <= '0;
      pass_q   <= '0;
      ctr_q    <= '0;
      ft_q     <= '0;
      cnt_q    <= '0;
      mrg_q    <= '0;
      flag_q   <= 1'b0;
      best_v_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == segfl_pkg::StFin);
      if (ctl_o.shift) pos_q <= last_pos ? '0 : pos_q + IW'(1);
      else pos_q <= '0;
      if ((state_q == segfl_pkg::StSort1) || (state_q == segfl_pkg::StSort2)) begin
        if (last_pos) pass_q <= last_pass ? '0 : pass_q + IW'(1);
      end else begin
        pass_q <= '0;
      end
      if (ins) ctr_q <= ctr_q + 1'b1;
      if (state_q == segfl_pkg::StFix) begin
        ft_q  <= '0;
        cnt_q <= '0;
      end else begin
        ft_q  <= ft_d;
        cnt_q <= cnt_d;
      end
      if (accept) begin
        flag_q   <= 1'b0;
        best_v_q <= 1'b0;
        mrg_q    <= '0;
      end else begin
        if (ins) flag_q <= 1'b1;
        if ((state_q == segfl_pkg::StScan) && better) best_v_q <= 1'b1;
        if ((state_q == segfl_pkg::StMerge) && mergeable) mrg_q <= mrg_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stat_q  <= (segfl_pkg::cmd_e'(command_i) == segfl_pkg::CmdAlloc && round[SW]) ?
                 segfl_pkg::StatNoFit : segfl_pkg::StatOk;
      gaddr_q <= '0;
      mout_q  <= '0;
      req_q   <= round;
      addr_q  <= block_address_i;
      size_q  <= byte_size_i;
    end
    unique case (state_q)
      segfl_pkg::StAdd: begin
        if (last_pos && !(flag_q || ins)) stat_q <= segfl_pkg::StatFull;
      end
      segfl_pkg::StScan: begin
        if (better) begin
          best_idx_q  <= pos_q;
          best_addr_q <= h0_i.addr;
          best_size_q <= h0_i.size;
          best_cls_q  <= h0_i.cls;
          best_dist_q <= age_gap;
        end
        if (last_pos && !(best_v_q || better)) stat_q <= segfl_pkg::StatNoFit;
      end
      segfl_pkg::StTake: gaddr_q <= best_addr_q;
      segfl_pkg::StSort1: acc_q.valid <= 1'b0;
      segfl_pkg::StMerge: begin
        if (mergeable) acc_q.size <= size_sum[SW-1:0];
        else acc_q <= h0_i;
      end
      segfl_pkg::StAssign: mout_q <= segfl_pkg::OutCntW'(mrg_q);
      default: ;
    endcase
  end

  assign done_o            = done_q;
  assign status_o          = stat_q;
  assign granted_address_o = gaddr_q;
  assign merge_count_o     = mout_q;
  assign free_bytes_o      = ft_q;
  assign block_total_o     = segfl_pkg::OutCntW'(cnt_q);

endmodule

/* rtl/segfl_checker.sv */
module segfl_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start_i,
  input logic                          busy_o,
  input logic                          done_o,
  input logic [segfl_pkg::StatW-1:0]   status_o,
  input logic [segfl_pkg::AddrW-1:0]   granted_address_o,
  input logic [segfl_pkg::OutCntW-1:0] merge_count_o
);

  // a taken command keeps the block busy or finishes at once
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o || done_o)
    else $error("command beat taken but block neither busy nor done");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while busy");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_nofit_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o != segfl_pkg::StatOk) |-> granted_address_o == '0)
    else $error("address granted on failed command");

  a_merge_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (merge_count_o != '0) |-> status_o == segfl_pkg::StatOk)
    else $error("merges reported with error status");

endmodule

bind segregated_free_list_allocator segfl_checker u_segfl_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .start_i           (start_i),
  .busy_o            (busy_o),
  .done_o            (done_o),
  .status_o          (status_o),
  .granted_address_o (granted_address_o),
  .merge_count_o     (merge_count_o)
);

/* tb/sv/segregated_free_list_allocator_test.sv */
module segregated_free_list_allocator_test;

  localparam int unsigned Slots = segfl_pkg::DefSlots;
  localparam int unsigned AddrW = segfl_pkg::AddrW;
  localparam int unsigned SizeW = segfl_pkg::SizeW;
  localparam int unsigned AgeW = segfl_pkg::AgeW;
  localparam int unsigned TotalW = segfl_pkg::TotalW;
  localparam int unsigned OutCntW = segfl_pkg::OutCntW;
  localparam int unsigned CmdW = segfl_pkg::CmdW;
  localparam int unsigned StatW = segfl_pkg::StatW;
  localparam int unsigned ClassCount = segfl_pkg::ClassCount;
  localparam int unsigned MinClass = segfl_pkg::MinClass;
  localparam int unsigned MinRem = segfl_pkg::MinRem;
  localparam longint unsigned CycleLimit = 40_000_000;
  localparam int unsigned RandomBeats = 1100;

  typedef struct {
    segfl_pkg::cmd_e  cmd;
    logic [AddrW-1:0] addr;
    logic [SizeW-1:0] size;
    bit               drain;
    int unsigned      gap;
  } request_t;

  typedef struct {
    segfl_pkg::stat_e   status;
    logic [AddrW-1:0]   granted;
    logic [OutCntW-1:0] merges;
    logic [TotalW-1:0]  free_bytes;
    logic [OutCntW-1:0] blocks;
  } outcome_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic [CmdW-1:0]     command_i;
  logic [AddrW-1:0]    block_address_i;
  logic [SizeW-1:0]    byte_size_i;
  logic                busy_o;
  logic                done_o;
  logic [StatW-1:0]    status_o;
  logic [AddrW-1:0]    granted_address_o;
  logic [OutCntW-1:0]  merge_count_o;
  logic [TotalW-1:0]   free_bytes_o;
  logic [OutCntW-1:0]  block_total_o;

  segregated_free_list_allocator u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .command_i         (command_i),
    .block_address_i   (block_address_i),
    .byte_size_i       (byte_size_i),
    .busy_o            (busy_o),
    .done_o            (done_o),
    .status_o          (status_o),
    .granted_address_o (granted_address_o),
    .merge_count_o     (merge_count_o),
    .free_bytes_o      (free_bytes_o),
    .block_total_o     (block_total_o)
  );

  // free table as the predictor sees it
  bit               fl_valid[Slots];
  logic [AddrW-1:0] fl_addr[Slots];
  logic [SizeW-1:0] fl_size[Slots];
  int unsigned      fl_class[Slots];
  logic [AgeW-1:0]  fl_age[Slots];
  logic [AgeW-1:0]  fl_next_age;
  logic [TotalW-1:0] fl_total;

  request_t pending_q[$];
  outcome_t outcome_q[$];
  logic     taken;
  longint unsigned cycles;
  int unsigned errors, n_add, n_alloc, n_coal, n_full, n_nofit, n_merges;
  logic [AddrW-1:0] carve_ptr;
  bit zero_gaps;

  function automatic int unsigned size_class(longint unsigned s);
    int unsigned c;
    longint unsigned lim;
    c = 0;
    lim = MinClass;
    while (c < ClassCount - 1 && s > lim) begin
      lim = lim << 1;
      c++;
    end
    return c;
  endfunction

  function automatic bit table_insert(logic [AddrW-1:0] a, logic [SizeW-1:0] s);
    for (int i = 0; i < Slots; i++) begin
      if (!fl_valid[i]) begin
        fl_valid[i] = 1'b1;
        fl_addr[i] = a;
        fl_size[i] = s;
        fl_class[i] = size_class(s);
        fl_age[i] = fl_next_age;
        fl_next_age = fl_next_age + 1;
        fl_total = fl_total + TotalW'(s);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic outcome_t predict_outcome(request_t r);
    outcome_t o;
    longint unsigned req, sa[Slots], ss[Slots], a, s;
    int best, n, j, m;
    logic [AgeW-1:0] age_gap, best_dist;
    logic [SizeW-1:0] rem;
    bit found;
    o.status = segfl_pkg::StatOk;
    o.granted = '0;
    o.merges = '0;
    found = 1'b0;
    case (r.cmd)
      segfl_pkg::CmdAdd: begin
        if (!table_insert(r.addr, r.size)) o.status = segfl_pkg::StatFull;
      end
      segfl_pkg::CmdAlloc: begin
        req = (longint'(r.size) + 7) & ~64'd7;
        if (req <= 64'hFFFF_FFFF) begin
          for (int c = size_class(req); c < ClassCount && !found; c++) begin
            best = -1;
            best_dist = '0;
            for (int i = 0; i < Slots; i++) begin
              if (fl_valid[i] && fl_class[i] == c && fl_size[i] >= req) begin
                age_gap = fl_next_age - fl_age[i];
                if (best < 0 || age_gap < best_dist) begin
                  best = i;
                  best_dist = age_gap;
                end
              end
            end
            if (best >= 0) begin
              found = 1'b1;
              o.granted = fl_addr[best];
              rem = fl_size[best] - SizeW'(req);
              fl_valid[best] = 1'b0;
              fl_total = fl_total - TotalW'(fl_size[best]);
              if (rem >= MinRem) void'(table_insert(o.granted + AddrW'(req), rem));
            end
          end
        end
        if (!found) o.status = segfl_pkg::StatNoFit;
      end
      segfl_pkg::CmdCoalesce: begin
        n = 0;
        for (int i = 0; i < Slots; i++) begin
          if (fl_valid[i]) begin
            a = fl_addr[i];
            s = fl_size[i];
            j = n;
            while (j > 0 && (sa[j-1] > a || (sa[j-1] == a && ss[j-1] > s))) begin
              sa[j] = sa[j-1];
              ss[j] = ss[j-1];
              j--;
            end
            sa[j] = a;
            ss[j] = s;
            n++;
          end
          fl_valid[i] = 1'b0;
        end
        fl_total = '0;
        if (n > 0) begin
          m = 0;
          for (int i = 1; i < n; i++) begin
            // an address sum past 48 bits never touches the next block
            if (sa[m] + ss[m] == sa[i] && ss[m] + ss[i] <= 64'hFFFF_FFFF) begin
              ss[m] += ss[i];
              o.merges++;
            end else begin
              m++;
              sa[m] = sa[i];
              ss[m] = ss[i];
            end
          end
          for (int i = 0; i <= m; i++) void'(table_insert(AddrW'(sa[i]), SizeW'(ss[i])));
        end
      end
      default: ;
    endcase
    o.free_bytes = fl_total;
    o.blocks = '0;
    for (int i = 0; i < Slots; i++) o.blocks += OutCntW'(fl_valid[i]);
    return o;
  endfunction

  function automatic void queue_request(segfl_pkg::cmd_e c, logic [AddrW-1:0] a,
                                        logic [SizeW-1:0] s, bit drain);
    request_t r;
    r.cmd = c;
    r.addr = a;
    r.size = s;
    r.drain = drain;
    r.gap = zero_gaps ? 0 : $urandom_range(0, 5);
    pending_q = {pending_q, r};
  endfunction

  // adjacent blocks carved from one region so that coalesce finds merges
  function automatic void queue_carved_add(bit drain);
    logic [SizeW-1:0] s;
    s = ($urandom_range(0, 19) == 0) ? SizeW'($urandom_range(4096, 70000))
                                      : SizeW'($urandom_range(0, 600));
    if ($urandom_range(0, 3) == 0) carve_ptr += AddrW'($urandom_range(1, 64));
    queue_request(segfl_pkg::CmdAdd, carve_ptr, s, drain);
    carve_ptr += AddrW'(s);
  endfunction

  function automatic void build_stimulus();
    int unsigned mode, r;
    zero_gaps = 1'b0;
    queue_request(segfl_pkg::CmdCoalesce, '0, '0, 1'b0);
    queue_request(segfl_pkg::CmdAlloc, '0, 32'd8, 1'b0);
    queue_request(segfl_pkg::CmdNop, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    queue_request(segfl_pkg::CmdAdd, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    queue_request(segfl_pkg::CmdAdd, '0, '0, 1'b0);
    queue_request(segfl_pkg::CmdAlloc, '0, '0, 1'b0);
    queue_request(segfl_pkg::CmdAlloc, '0, 32'hFFFF_FFF9, 1'b0);
    queue_request(segfl_pkg::CmdAlloc, '0, 32'hFFFF_FFF8, 1'b0);
    // touching pair whose summed size is too big to merge
    queue_request(segfl_pkg::CmdAdd, 48'h1000, 32'h8000_0000, 1'b0);
    queue_request(segfl_pkg::CmdAdd, 48'h8000_1000, 32'h8000_0000, 1'b0);
    queue_request(segfl_pkg::CmdAdd, 48'h1000, 32'h10, 1'b0);
    queue_request(segfl_pkg::CmdAdd, 48'h2_0000, 32'd100, 1'b0);
    queue_request(segfl_pkg::CmdAdd, 48'h2_0064, 32'd28, 1'b0);
    queue_request(segfl_pkg::CmdAdd, 48'h2_0080, 32'd4097, 1'b0);
    queue_request(segfl_pkg::CmdAdd, 48'hFFFF_FFFF_FFF0, 32'h20, 1'b0);
    queue_request(segfl_pkg::CmdCoalesce, '0, '0, 1'b1);
    queue_request(segfl_pkg::CmdAlloc, '0, 32'd41, 1'b0);
    queue_request(segfl_pkg::CmdAlloc, '0, 32'd4090, 1'b0);
    queue_request(segfl_pkg::CmdAlloc, '0, 32'd9, 1'b0);
    queue_request(segfl_pkg::CmdCoalesce, '0, '0, 1'b0);
    carve_ptr = AddrW'({$urandom, $urandom}) & 48'h0FFF_FFFF_FFF8;
    for (int unsigned k = 0; k < RandomBeats; k++) begin
      if (k % 40 == 0) begin
        mode = $urandom_range(0, 2);
        zero_gaps = $urandom_range(0, 2) == 0;
      end
      r = $urandom_range(0, 99);
      if (r < 8) begin
        queue_request(segfl_pkg::cmd_e'($urandom_range(0, 3)), AddrW'({$urandom, $urandom}),
                      $urandom, k % 40 == 0);
      end else if (r < 11) begin
        queue_request(segfl_pkg::CmdCoalesce, '0, '0, k % 40 == 0);
      end else if (r < (mode == 0 ? 80 : mode == 1 ? 55 : 35)) begin
        queue_carved_add(k % 40 == 0);
      end else begin
        queue_request(segfl_pkg::CmdAlloc, '0,
                      ($urandom_range(0, 15) == 0) ? $urandom
                                                   : SizeW'($urandom_range(0, 700)),
                      k % 40 == 0);
      end
    end
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // driver: one beat at a time, gaps and drain holds taken at the falling edge
  always @(negedge clk_i) begin
    if (rst_ni && !(start_i && !taken)) begin
      if (pending_q.size() > 0 && pending_q[0].gap > 0) begin
        pending_q[0].gap--;
        start_i <= 1'b0;
      end else if (pending_q.size() > 0 && (!pending_q[0].drain || outcome_q.size() == 0)) begin
        command_i <= pending_q[0].cmd;
        block_address_i <= pending_q[0].addr;
        byte_size_i <= pending_q[0].size;
        start_i <= 1'b1;
        void'(pending_q.pop_front());
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // monitor: predict on each accepted beat, check on each done strobe
  always @(posedge clk_i) begin
    request_t r;
    outcome_t e;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t timeout with %0d results outstanding", $time, outcome_q.size());
      $display("FAILED: results differ");
      $finish;
    end
    taken <= rst_ni && start_i && !busy_o;
    if (rst_ni && start_i && !busy_o) begin
      r.cmd = segfl_pkg::cmd_e'(command_i);
      r.addr = block_address_i;
      r.size = byte_size_i;
      e = predict_outcome(r);
      outcome_q = {outcome_q, e};
      n_add += r.cmd == segfl_pkg::CmdAdd;
      n_alloc += r.cmd == segfl_pkg::CmdAlloc;
      n_coal += r.cmd == segfl_pkg::CmdCoalesce;
      n_full += e.status == segfl_pkg::StatFull;
      n_nofit += e.status == segfl_pkg::StatNoFit;
      n_merges += e.merges;
    end
    if (rst_ni && done_o) begin
      if (outcome_q.size() == 0) begin
        $display("%0t result with nothing expected: status %0d", $time, status_o);
        errors++;
      end else begin
        e = outcome_q.pop_front();
        if (status_o !== e.status) begin
          $display("%0t status expected %0d actual %0d", $time, e.status, status_o);
          errors++;
        end
        if (granted_address_o !== e.granted) begin
          $display("%0t granted_address expected %h actual %h", $time, e.granted,
                   granted_address_o);
          errors++;
        end
        if (merge_count_o !== e.merges) begin
          $display("%0t merge_count expected %0d actual %0d", $time, e.merges,
                   merge_count_o);
          errors++;
        end
        if (free_bytes_o !== e.free_bytes) begin
          $display("%0t free_bytes expected %0d actual %0d", $time, e.free_bytes,
                   free_bytes_o);
          errors++;
        end
        if (block_total_o !== e.blocks) begin
          $display("%0t block_total expected %0d actual %0d", $time, e.blocks,
                   block_total_o);
          errors++;
        end
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    start_i = 1'b0;
    command_i = segfl_pkg::CmdNop;
    block_address_i = '0;
    byte_size_i = '0;
    taken = 1'b0;
    cycles = 0;
    errors = 0;
    n_add = 0;
    n_alloc = 0;
    n_coal = 0;
    n_full = 0;
    n_nofit = 0;
    n_merges = 0;
    fl_next_age = '0;
    fl_total = '0;
    for (int i = 0; i < Slots; i++) fl_valid[i] = 1'b0;
    build_stimulus();
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    while (pending_q.size() > 0 || start_i || outcome_q.size() > 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (outcome_q.size() > 0) errors++;
    $display("covered %0d adds (%0d dropped on a full table), %0d allocates (%0d unmet),",
             n_add, n_full, n_alloc, n_nofit);
    $display("%0d coalesce passes with %0d merges, %0d mismatches", n_coal, n_merges, errors);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* segregated_free_list_allocator.f */
rtl/segfl_pkg.sv
rtl/segfl_cell.sv
rtl/segfl_ctrl.sv
rtl/segregated_free_list_allocator.sv
rtl/segfl_checker.sv
tb/sv/segregated_free_list_allocator_test.sv
